// ===== src/fdtd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fdtd_pkg;

  // Operand limit before the count saturates
  localparam int MaxOperandsDef = 48;

  // Byte codes of the DICT encoding
  localparam logic [7:0] OpLast      = 8'd21;
  localparam logic [7:0] OpEscape    = 8'd12;
  localparam logic [7:0] LeadInt16   = 8'd28;
  localparam logic [7:0] LeadInt32   = 8'd29;
  localparam logic [7:0] LeadReal    = 8'd30;
  localparam logic [7:0] OneByteLo   = 8'd32;
  localparam logic [7:0] OneByteHi   = 8'd246;
  localparam logic [7:0] PosShortLo  = 8'd247;
  localparam logic [7:0] PosShortHi  = 8'd250;
  localparam logic [7:0] NegShortLo  = 8'd251;
  localparam logic [7:0] NegShortHi  = 8'd254;
  localparam logic [7:0] OneByteBias = 8'd139;
  localparam logic [7:0] ShortBias   = 8'd108;
  localparam logic [3:0] RealEndNib  = 4'hf;

  // Token kinds
  localparam logic [1:0] KindInt    = 2'd0;
  localparam logic [1:0] KindOp     = 2'd1;
  localparam logic [1:0] KindReal   = 2'd2;
  localparam logic [1:0] KindReport = 2'd3;

  // Error codes
  localparam logic [2:0] ErrNone      = 3'd0;
  localparam logic [2:0] ErrReserved  = 3'd1;
  localparam logic [2:0] ErrLeftover  = 3'd2;
  localparam logic [2:0] ErrTruncated = 3'd3;
  localparam logic [2:0] ErrOverflow  = 3'd4;

  // Packed output data width (63 field bits, padded to whole bytes)
  localparam int OutDataW = 64;

  typedef enum logic [2:0] {
    PhIdle,
    PhEscape,
    PhShort,
    PhMulti,
    PhReal
  } phase_e;

  typedef struct packed {
    logic [1:0]         tok_kind;
    logic signed [31:0] int_value;
    logic [4:0]         op_code;
    logic [7:0]         op_escape;
    logic [5:0]         operand_count;
    logic [7:0]         real_nibbles;
    logic               real_done;
    logic [2:0]         error_code;
    logic               dict_end;
  } token_t;

endpackage

`default_nettype wire

// ===== src/font_dict_token_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  tdata                      tuser      tlast
// s_axis    in   dict_byte                  -          last_in_dict
// m_axis    out  value/op/count/real/error  tok_kind   dict_end
//
// One DICT byte per cycle is accepted while the output is not stalled; a byte taken
// in reaches the output through the input register and then the result register.
// Bytes that only open or continue a token produce no output request unless they end the dict.
// A stalled output holds; the input register still takes one more byte.
// Reset clears the decode phase, the operand count and both valid flags.

module font_dict_token_decoder_top #(
  parameter int MAX_OPERANDS = fdtd_pkg::MaxOperandsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] dict_byte
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [fdtd_pkg::OutDataW-1:0] m_axis_tdata_o,
  // [31:0] int_value, [36:32] op_code, [44:37] op_escape,
  // [50:45] operand_count, [58:51] real_nibbles, [59] real_done,
  // [62:60] error_code, [63] zero
  output logic [1:0]       m_axis_tuser_o,   // [1:0] tok_kind
  output logic             m_axis_tlast_o
);

  import fdtd_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;
  logic       out_free;
  logic       emit;
  token_t     tok;
  token_t     m_tok;

  // Advance the held byte whenever the result slot can take its token
  assign advance = in_valid && out_free;

  fdtd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_byte_i  (s_axis_tdata_i),
    .s_last_i  (s_axis_tlast_i),
    .advance_i (advance),
    .valid_o   (in_valid),
    .byte_o    (in_byte),
    .last_o    (in_last)
  );

  fdtd_decode #(
    .MAX_OPERANDS (MAX_OPERANDS)
  ) u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (advance),
    .byte_i  (in_byte),
    .last_i  (in_last),
    .emit_o  (emit),
    .tok_o   (tok)
  );

  fdtd_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (emit),
    .tok_i     (tok),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_tok_o   (m_tok)
  );

  // Pack the result fields
  assign m_axis_tdata_o = {1'b0, m_tok.error_code, m_tok.real_done, m_tok.real_nibbles,
                           m_tok.operand_count, m_tok.op_escape, m_tok.op_code,
                           m_tok.int_value};
  assign m_axis_tuser_o = m_tok.tok_kind;
  assign m_axis_tlast_o = m_tok.dict_end;

endmodule

`default_nettype wire

// ===== src/fdtd_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fdtd_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_valid_i,
  output logic            s_ready_o,
  input  wire logic [7:0] s_byte_i,
  input  wire logic       s_last_i,
  input  wire logic       advance_i,
  output logic            valid_o,
  output logic [7:0]      byte_o,
  output logic            last_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       take;

  // Take a new request when the slot is empty or drains this cycle
  assign s_ready_o = !valid_q || advance_i;
  assign take      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload until it is consumed
  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= s_byte_i;
      last_q <= s_last_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

// ===== src/fdtd_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fdtd_decode #(
  parameter int MAX_OPERANDS = fdtd_pkg::MaxOperandsDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output logic            emit_o,
  output fdtd_pkg::token_t tok_o
);

  import fdtd_pkg::*;

  localparam logic [5:0] MaxOps = 6'(MAX_OPERANDS);

  phase_e      phase_q, phase_d;
  logic [1:0]  rem_q, rem_d;
  logic [7:0]  lead_q, lead_d;
  logic [31:0] part_q, part_d;
  logic [5:0]  cnt_q, cnt_d;

  logic        emit;
  token_t      tok;
  logic        overflow;
  logic        reserved;
  logic        cnt_full;
  logic [5:0]  cnt_next;
  logic [1:0]  hi_off;
  logic [10:0] mag;
  logic [31:0] shifted;

  // Counter step for one more operand, saturating at the limit
  assign cnt_full = (cnt_q >= MaxOps);
  assign cnt_next = cnt_full ? MaxOps : cnt_q + 6'd1;

  // Two-byte operand magnitude
  assign hi_off  = (lead_q <= PosShortHi) ? 2'(lead_q - PosShortLo) : 2'(lead_q - NegShortLo);
  assign mag     = {1'b0, hi_off, 8'h00} + {3'b000, byte_i} + {3'b000, ShortBias};
  assign shifted = {part_q[23:0], byte_i};

  always_comb begin
    phase_d  = phase_q;
    rem_d    = rem_q;
    lead_d   = lead_q;
    part_d   = part_q;
    cnt_d    = cnt_q;
    emit     = 1'b0;
    overflow = 1'b0;
    reserved = 1'b0;
    tok      = '0;
    tok.tok_kind = KindReport;

    unique case (phase_q)
      PhIdle: begin
        priority if (byte_i <= OpLast) begin
          if (byte_i == OpEscape) begin
            phase_d = PhEscape;
          end else begin
            emit              = 1'b1;
            tok.tok_kind      = KindOp;
            tok.op_code       = byte_i[4:0];
            tok.operand_count = cnt_q;
            cnt_d             = '0;
          end
        end else if (byte_i == LeadInt16 || byte_i == LeadInt32) begin
          lead_d  = byte_i;
          part_d  = '0;
          rem_d   = (byte_i == LeadInt16) ? 2'd1 : 2'd3;
          phase_d = PhMulti;
        end else if (byte_i == LeadReal) begin
          phase_d = PhReal;
        end else if (byte_i >= OneByteLo && byte_i <= OneByteHi) begin
          emit          = 1'b1;
          tok.tok_kind  = KindInt;
          tok.int_value = 32'(signed'({1'b0, byte_i} - {1'b0, OneByteBias}));
          overflow      = cnt_full;
          cnt_d         = cnt_next;
        end else if (byte_i >= PosShortLo && byte_i <= NegShortHi) begin
          lead_d  = byte_i;
          phase_d = PhShort;
        end else begin
          // Reserved byte at a token start
          emit     = 1'b1;
          reserved = 1'b1;
        end
      end
      PhEscape: begin
        emit              = 1'b1;
        tok.tok_kind      = KindOp;
        tok.op_code       = OpEscape[4:0];
        tok.op_escape     = byte_i;
        tok.operand_count = cnt_q;
        cnt_d             = '0;
        phase_d           = PhIdle;
      end
      PhShort: begin
        emit         = 1'b1;
        tok.tok_kind = KindInt;
        if (lead_q <= PosShortHi) begin
          tok.int_value = signed'({21'd0, mag});
        end else begin
          tok.int_value = signed'(32'd0 - {21'd0, mag});
        end
        overflow = cnt_full;
        cnt_d    = cnt_next;
        phase_d  = PhIdle;
      end
      PhMulti: begin
        if (rem_q == 2'd0) begin
          emit         = 1'b1;
          tok.tok_kind = KindInt;
          if (lead_q == LeadInt16) begin
            tok.int_value = signed'({{16{shifted[15]}}, shifted[15:0]});
          end else begin
            tok.int_value = signed'(shifted);
          end
          overflow = cnt_full;
          cnt_d    = cnt_next;
          part_d   = '0;
          phase_d  = PhIdle;
        end else begin
          part_d = shifted;
          rem_d  = rem_q - 2'd1;
        end
      end
      PhReal: begin
        emit             = 1'b1;
        tok.tok_kind     = KindReal;
        tok.real_nibbles = byte_i;
        if (byte_i[3:0] == RealEndNib) begin
          tok.real_done = 1'b1;
          overflow      = cnt_full;
          cnt_d         = cnt_next;
          phase_d       = PhIdle;
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase

    // Error priority: reserved, then overflow; dict end may override
    if (reserved) begin
      tok.error_code = ErrReserved;
    end else if (overflow) begin
      tok.error_code = ErrOverflow;
    end else begin
      tok.error_code = ErrNone;
    end

    // Close the dict: report truncation or leftover operands, clear state
    if (last_i) begin
      if (!reserved && phase_d != PhIdle) begin
        tok.error_code = ErrTruncated;
      end else if (tok.error_code == ErrNone && cnt_d != '0) begin
        tok.error_code = ErrLeftover;
      end
      emit         = 1'b1;
      tok.dict_end = 1'b1;
      phase_d      = PhIdle;
      rem_d        = '0;
      lead_d       = '0;
      part_d       = '0;
      cnt_d        = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      rem_q   <= '0;
      lead_q  <= '0;
      part_q  <= '0;
      cnt_q   <= '0;
    end else if (valid_i) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      lead_q  <= lead_d;
      part_q  <= part_d;
      cnt_q   <= cnt_d;
    end
  end

  assign emit_o = valid_i && emit;
  assign tok_o  = tok;

endmodule

`default_nettype wire

// ===== src/fdtd_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fdtd_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire fdtd_pkg::token_t tok_i,
  output logic                  free_o,
  output logic                  m_valid_o,
  input  wire logic             m_ready_i,
  output fdtd_pkg::token_t      m_tok_o
);

  import fdtd_pkg::*;

  logic   valid_q, valid_d;
  token_t tok_q;

  // Slot is free when empty or when its request leaves this cycle
  assign free_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tok_q <= tok_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_tok_o   = tok_q;

endmodule

`default_nettype wire

// ===== src/fdtd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fdtd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [fdtd_pkg::OutDataW-1:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  import fdtd_pkg::*;

  // Hold a stalled output request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("stalled output request changed");

  // Leftover and truncation errors come only with the dict end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[62:60] == ErrLeftover
      || m_axis_tdata_o[62:60] == ErrTruncated) |-> m_axis_tlast_o)
    else $error("end error without dict end");

  // A reserved byte yields a report token
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[62:60] == ErrReserved |->
      m_axis_tuser_o == KindReport)
    else $error("reserved error on a non-report token");

  // The real terminator flag appears only on real tokens
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[59] |-> m_axis_tuser_o == KindReal)
    else $error("real_done on a non-real token");

  // A new output request follows an input request, through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o, 2))
    else $error("output request without matching input request");

endmodule

bind font_dict_token_decoder_top fdtd_checker u_checker (.*);

`default_nettype wire

// ===== bench/font_dict_token_decoder_top_tb.sv =====
`timescale 1ns / 1ps

module font_dict_token_decoder_top_tb;
  import fdtd_pkg::*;

  localparam int StallLimit = 2000;
  localparam int RandomBytes = 1050;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata = 8'd0;
  logic       s_tlast = 1'b0;
  logic       m_tready = 1'b0;

  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [1:0]          m_axis_tuser_o;
  logic                m_axis_tlast_o;

  // Decoder mirror
  phase_e      dec_phase;
  logic [1:0]  bytes_left;
  logic [7:0]  lead;
  logic [31:0] partial;
  logic [5:0]  pending;

  token_t     expected_tokens[$];
  logic [7:0] dict_bytes[$];

  int mismatches = 0;
  int bytes_sent = 0;
  int idle_cycles = 0;
  int hold_req = 0;
  int hold_left = 0;
  bit steady_flow = 1'b0;

  font_dict_token_decoder_top #(
    .MAX_OPERANDS(MaxOperandsDef)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  // Return the mirror to its post-reset state
  function automatic void clear_decoder();
    dec_phase  = PhIdle;
    bytes_left = 2'd0;
    lead       = 8'd0;
    partial    = 32'd0;
    pending    = 6'd0;
  endfunction

  // Append one byte to the dict being built
  function automatic void add_byte(input logic [7:0] b);
    dict_bytes.insert(dict_bytes.size(), b);
  endfunction

  // Count one operand; report overflow once the count is saturated
  function automatic logic count_operand();
    if (pending >= MaxOperandsDef) begin
      pending = 6'(MaxOperandsDef);
      return 1'b1;
    end
    pending = pending + 6'd1;
    return 1'b0;
  endfunction

  // Decode one accepted byte and queue the token it completes, if any
  task automatic predict_token(input logic [7:0] b, input logic fin);
    token_t      t;
    logic        emit;
    logic        ovf;
    logic [31:0] mag;
    logic [15:0] low16;
    t = '0;
    t.tok_kind = KindReport;
    emit = 1'b0;
    ovf = 1'b0;
    case (dec_phase)
      PhIdle: begin
        if (b <= OpLast) begin
          if (b == OpEscape) begin
            dec_phase = PhEscape;
          end else begin
            emit = 1'b1;
            t.tok_kind = KindOp;
            t.op_code = b[4:0];
            t.operand_count = pending;
            pending = 6'd0;
          end
        end else if (b == LeadInt16 || b == LeadInt32) begin
          lead = b;
          partial = 32'd0;
          bytes_left = (b == LeadInt16) ? 2'd1 : 2'd3;
          dec_phase = PhMulti;
        end else if (b == LeadReal) begin
          dec_phase = PhReal;
        end else if (b >= OneByteLo && b <= OneByteHi) begin
          emit = 1'b1;
          t.tok_kind = KindInt;
          t.int_value = {24'd0, b} - {24'd0, OneByteBias};
          ovf = count_operand();
        end else if (b >= PosShortLo && b <= NegShortHi) begin
          lead = b;
          dec_phase = PhShort;
        end else begin
          emit = 1'b1;
          t.error_code = ErrReserved;
        end
      end
      PhEscape: begin
        emit = 1'b1;
        t.tok_kind = KindOp;
        t.op_code = OpEscape[4:0];
        t.op_escape = b;
        t.operand_count = pending;
        pending = 6'd0;
        dec_phase = PhIdle;
      end
      PhShort: begin
        emit = 1'b1;
        t.tok_kind = KindInt;
        if (lead <= PosShortHi) begin
          t.int_value = (({24'd0, lead} - {24'd0, PosShortLo}) << 8) + {24'd0, b}
                        + {24'd0, ShortBias};
        end else begin
          mag = (({24'd0, lead} - {24'd0, NegShortLo}) << 8) + {24'd0, b}
                + {24'd0, ShortBias};
          t.int_value = -mag;
        end
        ovf = count_operand();
        dec_phase = PhIdle;
      end
      PhMulti: begin
        partial = {partial[23:0], b};
        if (bytes_left == 2'd0) begin
          emit = 1'b1;
          t.tok_kind = KindInt;
          if (lead == LeadInt16) begin
            low16 = partial[15:0];
            t.int_value = {{16{low16[15]}}, low16};
          end else begin
            t.int_value = partial;
          end
          ovf = count_operand();
          dec_phase = PhIdle;
          partial = 32'd0;
        end else begin
          bytes_left = bytes_left - 2'd1;
        end
      end
      default: begin
        emit = 1'b1;
        t.tok_kind = KindReal;
        t.real_nibbles = b;
        if (b[3:0] == RealEndNib) begin
          t.real_done = 1'b1;
          ovf = count_operand();
          dec_phase = PhIdle;
        end
      end
    endcase

    if (ovf && t.error_code == ErrNone) t.error_code = ErrOverflow;

    // Dict end: truncation beats overflow, overflow beats leftover operands
    if (fin) begin
      if (t.error_code != ErrReserved && dec_phase != PhIdle) begin
        t.error_code = ErrTruncated;
      end else if (t.error_code == ErrNone && pending != 6'd0) begin
        t.error_code = ErrLeftover;
      end
      emit = 1'b1;
      t.dict_end = 1'b1;
      clear_decoder();
    end

    if (emit) expected_tokens.insert(expected_tokens.size(), t);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare one output request with the oldest expected token
  task automatic check_token();
    token_t t;
    if (expected_tokens.size() == 0) begin
      $error("unexpected token: kind %0d data 0x%0h", m_axis_tuser_o, m_axis_tdata_o);
      mismatches++;
    end else begin
      t = expected_tokens[0];
      expected_tokens.delete(0);
      check_field("tok_kind", 32'(t.tok_kind), 32'(m_axis_tuser_o));
      check_field("int_value", 32'(t.int_value), 32'(m_axis_tdata_o[31:0]));
      check_field("op_code", 32'(t.op_code), 32'(m_axis_tdata_o[36:32]));
      check_field("op_escape", 32'(t.op_escape), 32'(m_axis_tdata_o[44:37]));
      check_field("operand_count", 32'(t.operand_count), 32'(m_axis_tdata_o[50:45]));
      check_field("real_nibbles", 32'(t.real_nibbles), 32'(m_axis_tdata_o[58:51]));
      check_field("real_done", 32'(t.real_done), 32'(m_axis_tdata_o[59]));
      check_field("error_code", 32'(t.error_code), 32'(m_axis_tdata_o[62:60]));
      check_field("tdata_pad", 32'd0, 32'(m_axis_tdata_o[63]));
      check_field("dict_end", 32'(t.dict_end), 32'(m_axis_tlast_o));
    end
  endtask

  // Sample output requests and drive the output ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) check_token();
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (hold_req > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_req - 1;
      hold_req = 0;
    end else if (steady_flow) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= 20);
    end
  end

  // Stop the run when neither side moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("font_dict_token_decoder_top_tb NOT OK");
          $finish;
        end
      end
    end
  end

  // Offer one byte and hold it until the request is taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = 0;
    if (!steady_flow && $urandom_range(0, 99) < 12) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_token(b, fin);
    bytes_sent++;
  endtask

  task automatic release_bus();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Pause the sender until every expected token has come out
  task automatic wait_drained();
    release_bus();
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Send the collected bytes as one dict, marking the final byte
  task automatic send_dict();
    int i;
    for (i = 0; i < dict_bytes.size(); i++) begin
      send_byte(dict_bytes[i], i == dict_bytes.size() - 1);
    end
    dict_bytes.delete();
  endtask

  // Real body byte whose low nibble does not end the number
  function automatic logic [7:0] real_mid_byte();
    logic [7:0] v;
    v = 8'($urandom);
    if (v[3:0] == RealEndNib) v[3:0] = 4'($urandom_range(0, 14));
    return v;
  endfunction

  task automatic add_operand();
    logic [7:0] v;
    int n;
    case ($urandom_range(0, 5))
      0: add_byte(8'($urandom_range(OneByteLo, OneByteHi)));
      1: begin
        add_byte(8'($urandom_range(PosShortLo, PosShortHi)));
        add_byte(8'($urandom));
      end
      2: begin
        add_byte(8'($urandom_range(NegShortLo, NegShortHi)));
        add_byte(8'($urandom));
      end
      3: begin
        add_byte(LeadInt16);
        repeat (2) add_byte(8'($urandom));
      end
      4: begin
        add_byte(LeadInt32);
        repeat (4) add_byte(8'($urandom));
      end
      default: begin
        add_byte(LeadReal);
        n = $urandom_range(0, 3);
        repeat (n) add_byte(real_mid_byte());
        v = 8'($urandom);
        v[3:0] = RealEndNib;
        add_byte(v);
      end
    endcase
  endtask

  task automatic add_operator();
    if ($urandom_range(0, 99) < 15) begin
      add_byte(OpEscape);
      add_byte(8'($urandom));
    end else begin
      add_byte(8'($urandom_range(0, OpLast)));
    end
  endtask

  // Reserved bytes half the time, any byte otherwise
  task automatic add_noise();
    int r;
    r = $urandom_range(0, 15);
    if (r < 6) add_byte(8'(22 + r));
    else if (r == 6) add_byte(8'd31);
    else if (r == 7) add_byte(8'd255);
    else add_byte(8'($urandom));
  endtask

  // Open a token that the dict end will cut short
  task automatic add_broken_tail();
    int n;
    case ($urandom_range(0, 4))
      0: add_byte(OpEscape);
      1: begin
        add_byte(LeadInt16);
        if ($urandom_range(0, 1) == 1) add_byte(8'($urandom));
      end
      2: begin
        add_byte(LeadInt32);
        n = $urandom_range(0, 3);
        repeat (n) add_byte(8'($urandom));
      end
      3: add_byte(8'($urandom_range(PosShortLo, NegShortHi)));
      default: begin
        add_byte(LeadReal);
        n = $urandom_range(0, 2);
        repeat (n) add_byte(real_mid_byte());
      end
    endcase
  endtask

  // Every token form at a limit of its range, and operators of each shape
  task automatic test_token_forms();
    add_byte(8'd32);
    add_byte(8'd246);
    add_byte(8'd247); add_byte(8'd0);
    add_byte(8'd254); add_byte(8'd255);
    add_byte(LeadInt16); add_byte(8'h80); add_byte(8'h00);
    add_byte(LeadInt32); add_byte(8'h80); add_byte(8'h00);
    add_byte(8'h00); add_byte(8'h00);
    add_byte(LeadReal); add_byte(8'h1a); add_byte(8'hff);
    add_byte(8'd0);
    add_byte(OpEscape); add_byte(8'hff);
    add_byte(OpLast);
    send_dict();
    wait_drained();
  endtask

  // Reserved byte at the end, a cut escape, a cut real, leftover operands
  task automatic test_dict_end_errors();
    add_byte(8'd32); add_byte(8'd255);
    send_dict();
    add_byte(OpEscape);
    send_dict();
    add_byte(LeadReal); add_byte(8'h12);
    send_dict();
    add_byte(8'd139);
    send_dict();
    wait_drained();
  endtask

  // Hold the output off while the sender keeps offering bytes
  task automatic test_input_stall();
    steady_flow = 1'b1;
    hold_req = 80;
    repeat (30) add_byte(8'($urandom_range(OneByteLo, OneByteHi)));
    add_byte(OpLast);
    send_dict();
    steady_flow = 1'b0;
    wait_drained();
  endtask

  // Saturate the operand count, then end a dict on an overflowing operand
  task automatic test_operand_overflow();
    repeat (49) add_operand();
    add_byte(LeadReal); add_byte(8'h12); add_byte(8'h3f);
    add_byte(8'd0);
    repeat (48) add_byte(8'($urandom_range(OneByteLo, OneByteHi)));
    add_byte(8'd139);
    send_dict();
    wait_drained();
  endtask

  // Mostly well-formed dicts with random content, some noise and cut ends
  task automatic test_random_dicts();
    int start;
    int groups;
    int n_ops;
    int g;
    start = bytes_sent;
    while (bytes_sent - start < RandomBytes) begin
      steady_flow = (bytes_sent - start >= 500) && (bytes_sent - start < 750);
      groups = $urandom_range(1, 6);
      for (g = 0; g < groups; g++) begin
        if ($urandom_range(0, 99) < 8) add_noise();
        n_ops = ($urandom_range(0, 99) < 3) ? $urandom_range(44, 52) : $urandom_range(0, 5);
        repeat (n_ops) add_operand();
        if ($urandom_range(0, 99) < 90) add_operator();
      end
      if ($urandom_range(0, 99) < 12) add_broken_tail();
      if (dict_bytes.size() == 0) add_operator();
      send_dict();
      if ($urandom_range(0, 99) < 5) wait_drained();
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    clear_decoder();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_token_forms();
    test_dict_end_errors();
    test_input_stall();
    test_operand_overflow();
    test_random_dicts();

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (expected_tokens.size() != 0) begin
      $error("%0d expected tokens never came out", expected_tokens.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("font_dict_token_decoder_top_tb OK");
    end else begin
      $display("font_dict_token_decoder_top_tb NOT OK");
    end
    $finish;
  end

endmodule
